// ===== design/mexp_pkg.sv =====
// Package for the modular exponentiation unit: field widths, modulus constants,
// controller states and the command and status words between controller and datapath.
// No dependencies.
package mexp_pkg;

    localparam int BASE_W    = 63;
    localparam int EXP_W     = 63;
    localparam int POW_W     = 30;
    localparam int S_TDATA_W = 128;
    localparam int M_TDATA_W = 32;

    localparam int MUL_W     = 32;
    localparam int PROD_W    = 60;
    localparam int Q_W       = 31;
    localparam int CHUNK_W   = 21;
    localparam int NUM_CHUNKS = 3;
    localparam int CHUNK_CNT_W = 2;

    localparam int BARRETT_SHIFT_IN  = 29;
    localparam int BARRETT_SHIFT_OUT = 31;

    localparam logic [31:0] MODP       = 32'd1000000007;
    localparam logic [31:0] MODP_X2    = 32'd2000000014;
    localparam logic [31:0] BARRETT_MU = 32'd1152921496;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHUNK,
        ST_EST,
        ST_QMUL,
        ST_FIX,
        ST_PROD,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        PH_RED,
        PH_SQR,
        PH_MUL
    } phase_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CHUNK,
        OP_EST,
        OP_QMUL,
        OP_SQR,
        OP_MULB,
        OP_FIX_BASE,
        OP_FIX_ACC,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   shift_exp;
    } dp_cmd_t;

    typedef struct packed {
        logic exp_msb;
    } dp_stat_t;

endpackage

// ===== design/mexp_dp.sv =====
// Datapath of the modular exponentiation unit: operand registers, one shared
// 32x32 multiplier and the Barrett reduction steps modulo 1000000007.
// Depends on mexp_pkg.
module mexp_dp #(
    parameter int EXP_BITS = 63
) (
    input  logic                             clk,
    input  logic [mexp_pkg::S_TDATA_W-1:0]   in_data,
    input  mexp_pkg::dp_cmd_t                cmd,
    output mexp_pkg::dp_stat_t               stat,
    output logic [mexp_pkg::POW_W-1:0]       power
);

    logic [mexp_pkg::BASE_W-1:0]  base_in_reg, base_in_next;
    logic [EXP_BITS-1:0]          exp_reg, exp_next;
    logic [mexp_pkg::POW_W-1:0]   base_reg, base_next;
    logic [mexp_pkg::POW_W-1:0]   acc_reg, acc_next;
    logic [mexp_pkg::PROD_W-1:0]  x_reg, x_next;
    logic [mexp_pkg::Q_W-1:0]     q_reg, q_next;
    logic [mexp_pkg::MUL_W-1:0]   y_reg, y_next;
    logic [mexp_pkg::POW_W-1:0]   result_reg, result_next;

    logic [mexp_pkg::MUL_W-1:0]   mul_a;
    logic [mexp_pkg::MUL_W-1:0]   mul_b;
    logic [2*mexp_pkg::MUL_W-1:0] prod;
    logic [63:0]                  exp_ext;
    logic [mexp_pkg::MUL_W-1:0]   diff;
    logic [mexp_pkg::MUL_W-1:0]   fixed;

    always_comb
    begin
        case (cmd.op)
            mexp_pkg::OP_EST:
            begin
                mul_a = mexp_pkg::MUL_W'(x_reg[mexp_pkg::PROD_W-1:mexp_pkg::BARRETT_SHIFT_IN]);
                mul_b = mexp_pkg::BARRETT_MU;
            end
            mexp_pkg::OP_QMUL:
            begin
                mul_a = mexp_pkg::MUL_W'(q_reg);
                mul_b = mexp_pkg::MODP;
            end
            mexp_pkg::OP_SQR:
            begin
                mul_a = mexp_pkg::MUL_W'(acc_reg);
                mul_b = mexp_pkg::MUL_W'(acc_reg);
            end
            mexp_pkg::OP_MULB:
            begin
                mul_a = mexp_pkg::MUL_W'(acc_reg);
                mul_b = mexp_pkg::MUL_W'(base_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = (2*mexp_pkg::MUL_W)'(mul_a) * (2*mexp_pkg::MUL_W)'(mul_b);

    // The Barrett estimate is at most two short, so the remainder stays below 3P.
    always_comb
    begin
        diff = x_reg[mexp_pkg::MUL_W-1:0] - y_reg;
        if (diff >= mexp_pkg::MODP_X2)
        begin
            fixed = diff - mexp_pkg::MODP_X2;
        end
        else if (diff >= mexp_pkg::MODP)
        begin
            fixed = diff - mexp_pkg::MODP;
        end
        else
        begin
            fixed = diff;
        end
    end

    assign exp_ext = 64'(in_data[mexp_pkg::BASE_W +: mexp_pkg::EXP_W]);

    always_comb
    begin
        base_in_next = base_in_reg;
        exp_next     = exp_reg;
        base_next    = base_reg;
        acc_next     = acc_reg;
        x_next       = x_reg;
        q_next       = q_reg;
        y_next       = y_reg;
        result_next  = result_reg;
        case (cmd.op)
            mexp_pkg::OP_LOAD:
            begin
                base_in_next = in_data[mexp_pkg::BASE_W-1:0];
                exp_next     = exp_ext[EXP_BITS-1:0];
                acc_next     = mexp_pkg::POW_W'(1);
                base_next    = '0;
            end
            mexp_pkg::OP_CHUNK:
            begin
                x_next = mexp_pkg::PROD_W'({base_reg,
                    base_in_reg[mexp_pkg::BASE_W-1 -: mexp_pkg::CHUNK_W]});
                base_in_next = base_in_reg << mexp_pkg::CHUNK_W;
            end
            mexp_pkg::OP_EST:
            begin
                q_next = prod[mexp_pkg::BARRETT_SHIFT_OUT +: mexp_pkg::Q_W];
            end
            mexp_pkg::OP_QMUL:
            begin
                y_next = prod[mexp_pkg::MUL_W-1:0];
            end
            mexp_pkg::OP_SQR, mexp_pkg::OP_MULB:
            begin
                x_next = prod[mexp_pkg::PROD_W-1:0];
            end
            mexp_pkg::OP_FIX_BASE:
            begin
                base_next = fixed[mexp_pkg::POW_W-1:0];
            end
            mexp_pkg::OP_FIX_ACC:
            begin
                acc_next = fixed[mexp_pkg::POW_W-1:0];
            end
            mexp_pkg::OP_RESULT:
            begin
                result_next = acc_reg;
            end
            default:
            begin
            end
        endcase
        if (cmd.shift_exp)
        begin
            exp_next = exp_reg << 1;
        end
    end

    always_ff @(posedge clk)
    begin
        base_in_reg <= base_in_next;
        exp_reg     <= exp_next;
        base_reg    <= base_next;
        acc_reg     <= acc_next;
        x_reg       <= x_next;
        q_reg       <= q_next;
        y_reg       <= y_next;
        result_reg  <= result_next;
    end

    assign stat.exp_msb = exp_reg[EXP_BITS-1];
    assign power        = result_reg;

endmodule

// ===== design/mexp_ctrl.sv =====
// Controller of the modular exponentiation unit: sequences base reduction and the
// square-and-multiply steps, and owns the stream handshakes. Depends on mexp_pkg.
module mexp_ctrl #(
    parameter int EXP_BITS = 63
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  mexp_pkg::dp_stat_t stat,
    output mexp_pkg::dp_cmd_t  cmd
);

    localparam int CNT_W = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

    mexp_pkg::state_t state_reg, state_next;
    mexp_pkg::phase_t phase_reg, phase_next;
    logic [CNT_W-1:0]                 bit_cnt_reg, bit_cnt_next;
    logic [mexp_pkg::CHUNK_CNT_W-1:0] chunk_cnt_reg, chunk_cnt_next;
    logic                             out_valid_reg, out_valid_next;
    logic                             fin_ok;
    logic                             bit_done;

    assign fin_ok = !out_valid_reg || out_ready;

    always_comb
    begin
        bit_done = 1'b0;
        if (phase_reg == mexp_pkg::PH_MUL)
        begin
            bit_done = 1'b1;
        end
        else if (phase_reg == mexp_pkg::PH_SQR)
        begin
            bit_done = !stat.exp_msb;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        bit_cnt_next   = bit_cnt_reg;
        chunk_cnt_next = chunk_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            mexp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next     = mexp_pkg::ST_CHUNK;
                    phase_next     = mexp_pkg::PH_RED;
                    chunk_cnt_next = '0;
                    bit_cnt_next   = CNT_W'(EXP_BITS - 1);
                end
            end
            mexp_pkg::ST_CHUNK:
            begin
                state_next = mexp_pkg::ST_EST;
            end
            mexp_pkg::ST_PROD:
            begin
                state_next = mexp_pkg::ST_EST;
            end
            mexp_pkg::ST_EST:
            begin
                state_next = mexp_pkg::ST_QMUL;
            end
            mexp_pkg::ST_QMUL:
            begin
                state_next = mexp_pkg::ST_FIX;
            end
            mexp_pkg::ST_FIX:
            begin
                if (phase_reg == mexp_pkg::PH_RED)
                begin
                    if (chunk_cnt_reg == mexp_pkg::CHUNK_CNT_W'(mexp_pkg::NUM_CHUNKS - 1))
                    begin
                        state_next = mexp_pkg::ST_PROD;
                        phase_next = mexp_pkg::PH_SQR;
                    end
                    else
                    begin
                        state_next     = mexp_pkg::ST_CHUNK;
                        chunk_cnt_next = chunk_cnt_reg + 1'b1;
                    end
                end
                else if (!bit_done)
                begin
                    state_next = mexp_pkg::ST_PROD;
                    phase_next = mexp_pkg::PH_MUL;
                end
                else if (bit_cnt_reg == '0)
                begin
                    state_next = mexp_pkg::ST_FINISH;
                end
                else
                begin
                    state_next   = mexp_pkg::ST_PROD;
                    phase_next   = mexp_pkg::PH_SQR;
                    bit_cnt_next = bit_cnt_reg - 1'b1;
                end
            end
            mexp_pkg::ST_FINISH:
            begin
                if (fin_ok)
                begin
                    state_next     = mexp_pkg::ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = mexp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.op        = mexp_pkg::OP_NONE;
        cmd.shift_exp = 1'b0;
        in_ready      = 1'b0;
        case (state_reg)
            mexp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = mexp_pkg::OP_LOAD;
                end
            end
            mexp_pkg::ST_CHUNK:
            begin
                cmd.op = mexp_pkg::OP_CHUNK;
            end
            mexp_pkg::ST_EST:
            begin
                cmd.op = mexp_pkg::OP_EST;
            end
            mexp_pkg::ST_QMUL:
            begin
                cmd.op = mexp_pkg::OP_QMUL;
            end
            mexp_pkg::ST_FIX:
            begin
                if (phase_reg == mexp_pkg::PH_RED)
                begin
                    cmd.op = mexp_pkg::OP_FIX_BASE;
                end
                else
                begin
                    cmd.op        = mexp_pkg::OP_FIX_ACC;
                    cmd.shift_exp = bit_done;
                end
            end
            mexp_pkg::ST_PROD:
            begin
                if (phase_reg == mexp_pkg::PH_MUL)
                begin
                    cmd.op = mexp_pkg::OP_MULB;
                end
                else
                begin
                    cmd.op = mexp_pkg::OP_SQR;
                end
            end
            mexp_pkg::ST_FINISH:
            begin
                if (fin_ok)
                begin
                    cmd.op = mexp_pkg::OP_RESULT;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mexp_pkg::ST_IDLE;
            phase_reg     <= mexp_pkg::PH_RED;
            bit_cnt_reg   <= '0;
            chunk_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            bit_cnt_reg   <= bit_cnt_next;
            chunk_cnt_reg <= chunk_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== design/modular_exponentiation_unit.sv =====
// Modular exponentiation unit: base to the exponent modulo 1000000007, square and multiply.
// Every modular product passes through the multiply, Barrett estimate, quotient times modulus and
// correction steps on the one shared 32x32 multiplier; base reduction takes three such passes.
// One word is in work at a time; the next is taken once the result is in the output register.
// Reset clears the controller and the output valid flag; no state is kept between words.
module modular_exponentiation_unit #(
    parameter int EXP_BITS = 63
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [mexp_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // base[62:0], exponent[125:63]
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [mexp_pkg::M_TDATA_W-1:0]   m_axis_tdata   // power[29:0]
);

    mexp_pkg::dp_cmd_t            cmd;
    mexp_pkg::dp_stat_t           stat;
    logic [mexp_pkg::POW_W-1:0]   power;

    mexp_ctrl #(
        .EXP_BITS (EXP_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mexp_dp #(
        .EXP_BITS (EXP_BITS)
    ) u_dp (
        .clk     (clk),
        .in_data (s_axis_tdata),
        .cmd     (cmd),
        .stat    (stat),
        .power   (power)
    );

    assign m_axis_tdata = mexp_pkg::M_TDATA_W'(power);

    property p_busy_after_accept;
        @(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready;
    endproperty
    a_busy_after_accept: assert property (p_busy_after_accept)
        else $error("Input accepted while a word is still in work.");

    property p_power_reduced;
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (mexp_pkg::MUL_W'(m_axis_tdata[mexp_pkg::POW_W-1:0]) < mexp_pkg::MODP);
    endproperty
    a_power_reduced: assert property (p_power_reduced)
        else $error("Result is not reduced below the modulus.");

    property p_no_overwrite;
        @(posedge clk) disable iff (!rst_n)
        (cmd.op == mexp_pkg::OP_RESULT) |-> (!m_axis_tvalid || m_axis_tready);
    endproperty
    a_no_overwrite: assert property (p_no_overwrite)
        else $error("Result register written while a result is still pending.");

endmodule

// ===== tb/mexp_power_checker.sv =====
// Result checker for the modular exponentiation unit: watches both stream channels,
// predicts base to the exponent modulo the prime for every accepted word and compares.
// Depends on mexp_pkg for the field widths and the modulus.
module mexp_power_checker #(
    parameter int EXP_BITS = 63
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [mexp_pkg::S_TDATA_W-1:0] s_axis_tdata,  // base[62:0], exponent[125:63]
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [mexp_pkg::M_TDATA_W-1:0] m_axis_tdata,  // power[29:0]
    output int                             fail_count,
    output int                             words_due
);

    localparam logic [63:0] PRIME = 64'(mexp_pkg::MODP);

    logic [mexp_pkg::POW_W-1:0] power_due[$];
    int                         fails = 0;

    function automatic logic [mexp_pkg::POW_W-1:0] mod_power(
        input logic [mexp_pkg::BASE_W-1:0] base,
        input logic [mexp_pkg::EXP_W-1:0]  exponent);
        logic [63:0] reduced;
        logic [63:0] acc;
        reduced = {{(64 - mexp_pkg::BASE_W){1'b0}}, base} % PRIME;
        acc     = 64'd1;
        for (int i = EXP_BITS - 1; i >= 0; i--)
        begin
            acc = (acc * acc) % PRIME;
            if (i < mexp_pkg::EXP_W && exponent[i])
                acc = (acc * reduced) % PRIME;
        end
        return acc[mexp_pkg::POW_W-1:0];
    endfunction

    always @(posedge clk)
    begin
        logic [mexp_pkg::POW_W-1:0] want;
        logic [mexp_pkg::POW_W-1:0] got;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[mexp_pkg::POW_W-1:0];
                if (power_due.size() == 0)
                begin
                    $display("%0t unexpected word: expected none, actual %0d", $time, got);
                    fails++;
                end
                else
                begin
                    want = power_due.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t power mismatch: expected %0d, actual %0d",
                                 $time, want, got);
                        fails++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                power_due.insert(power_due.size(),
                    mod_power(s_axis_tdata[mexp_pkg::BASE_W-1:0],
                              s_axis_tdata[mexp_pkg::BASE_W+mexp_pkg::EXP_W-1:mexp_pkg::BASE_W]));
            fail_count <= fails;
            words_due  <= power_due.size();
        end
    end

endmodule

// ===== tb/tb_modular_exponentiation_unit.sv =====
// Testbench top for the modular exponentiation unit: clock, reset, directed and random
// words with random idling on both channels, and the final verdict.
// Depends on mexp_pkg, modular_exponentiation_unit and mexp_power_checker.
module tb_modular_exponentiation_unit;

    localparam int          EXP_SCAN   = 63;
    localparam int          NUM_RANDOM = 1600;
    localparam logic [62:0] P          = 63'd1000000007;
    localparam logic [62:0] ALL_ONES   = {63{1'b1}};

    logic                           clk;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [mexp_pkg::S_TDATA_W-1:0] s_axis_tdata;  // base[62:0], exponent[125:63]
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [mexp_pkg::M_TDATA_W-1:0] m_axis_tdata;  // power[29:0]
    int                             fail_count;
    int                             words_due;
    bit                             idle_on;

    modular_exponentiation_unit #(
        .EXP_BITS(EXP_SCAN)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    mexp_power_checker #(
        .EXP_BITS(EXP_SCAN)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .fail_count   (fail_count),
        .words_due    (words_due)
    );

    initial
        clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [62:0] random_wide();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[62:0];
    endfunction

    function automatic logic [62:0] random_base();
        logic [63:0] k;
        case ($urandom_range(0, 5))
            0, 1, 2: return random_wide();
            3:       return 63'($urandom_range(0, 15));
            4:
            begin
                k = 64'($urandom);
                return 63'(k * 64'(P) + 64'($urandom_range(0, 3)));
            end
            default: return P - 63'd1 + 63'($urandom_range(0, 2));
        endcase
    endfunction

    function automatic logic [62:0] random_exponent();
        case ($urandom_range(0, 5))
            0, 1, 2: return random_wide();
            3:       return 63'($urandom_range(0, 63));
            4:       return 63'd1 << $urandom_range(0, 62);
            default: return (P - 63'd1) * 63'($urandom_range(1, 4)) - 63'($urandom_range(0, 1));
        endcase
    endfunction

    task automatic send_word(input logic [62:0] base, input logic [62:0] exponent);
        int gap;
        gap = idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, exponent, base};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (words_due != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 11) : 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    initial
    begin
        #(4 * 4000000);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        idle_on       = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(63'd0, 63'd0);
        send_word(63'd0, 63'd1);
        send_word(P, 63'd0);
        send_word(P * 63'd7, 63'd0);
        send_word(ALL_ONES, 63'd0);
        send_word(P, 63'd5);
        send_word(P + 63'd1, 63'd12345);
        send_word(P - 63'd1, 63'd2);
        send_word(P - 63'd1, 63'd3);
        send_word(ALL_ONES, ALL_ONES);
        send_word(63'd1, ALL_ONES);
        send_word(63'd2, 63'd62);
        send_word(63'd2, 63'd1 << 62);
        send_word(63'd3, P - 63'd1);
        send_word(63'd2, P - 63'd2);
        send_word(63'd123456789, 63'd1);
        send_word(ALL_ONES, 63'd1);
        send_word(63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555);
        send_word(63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA);
        send_word(P * 63'd2 + 63'd5, ALL_ONES);
        drain();

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (n % 64 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            if (n == NUM_RANDOM / 2)
                drain();
            send_word(random_base(), random_exponent());
        end

        drain();
        repeat (600) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== modular_exponentiation_unit.f =====
design/mexp_pkg.sv
design/mexp_dp.sv
design/mexp_ctrl.sv
design/modular_exponentiation_unit.sv
tb/mexp_power_checker.sv
tb/tb_modular_exponentiation_unit.sv
